### hw/rtl/hbs_pkg.sv
package hbs_pkg;

  // frame geometry
  localparam int MAX_WIDTH = 1025;
  localparam int MIN_SIZE  = 3;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);

  // field widths
  localparam int SAMPLE_W = 8;
  localparam int ROW_W    = 13;
  localparam int COL_W    = 11;
  localparam int MEAN_W   = 16;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 2;

  // nine samples of 8 bits sum to at most 2295
  localparam int SUM_W = 12;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_EDGES   = 2'd2;

  localparam logic [COL_W-1:0] FRAME_WIDTH_RST  = 11'd257;
  localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST = 13'd257;
  localparam logic             ZERO_EDGES_RST   = 1'b1;

  // result slots of one item, in emit order
  localparam logic [1:0] SLOT_A = 2'd0;  // (r-1, c-1)
  localparam logic [1:0] SLOT_B = 2'd1;  // (r-1, w-1)
  localparam logic [1:0] SLOT_C = 2'd2;  // (r, c-1), bottom row
  localparam logic [1:0] SLOT_D = 2'd3;  // (r, w-1), bottom right corner

  // neighbor count of a box: corner, edge, interior
  typedef enum logic [1:0] {
    DIV4,
    DIV6,
    DIV9
  } div_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] older;
    logic [SAMPLE_W-1:0] prev;
  } line_pair_t;

  typedef struct packed {
    logic [3:0]       emit;
    logic [3:0]       zero;
    logic             rtop;
    logic             cleft;
    logic [ROW_W-1:0] row_up;
    logic [ROW_W-1:0] row_cur;
    logic [COL_W-1:0] col_left;
    logic [COL_W-1:0] col_cur;
  } item_ctl_t;

  typedef struct packed {
    logic [3:0][SUM_W-1:0] sum;
    div_t [3:0]            div;
  } box_sums_t;

endpackage

### hw/rtl/hbs_line_store.sv
module hbs_line_store (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [hbs_pkg::ADDR_W-1:0] rd_addr,
  output hbs_pkg::line_pair_t        rd_data,
  input  logic                       wr_en,
  input  logic [hbs_pkg::ADDR_W-1:0] wr_addr,
  input  hbs_pkg::line_pair_t        wr_data
);

  // both stored rows side by side, one entry per column
  hbs_pkg::line_pair_t mem [hbs_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/hbs_window.sv
module hbs_window (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [hbs_pkg::SAMPLE_W-1:0] older,
  input  logic [hbs_pkg::SAMPLE_W-1:0] prev,
  input  logic [hbs_pkg::SAMPLE_W-1:0] sample,
  input  hbs_pkg::item_ctl_t           in_ctl,
  output logic                         out_valid,
  input  logic                         out_ready,
  output hbs_pkg::item_ctl_t           out_ctl,
  output hbs_pkg::box_sums_t           out_sums
);

  // win[row][col]: row 0 oldest, col 2 newest
  logic [2:0][2:0][hbs_pkg::SAMPLE_W-1:0] win;
  logic                                   s2_valid;
  hbs_pkg::item_ctl_t                     s2_ctl;
  logic                                   in_take;
  logic                                   s2_go;

  logic [2:0][hbs_pkg::SAMPLE_W:0]   t;   // rows 1..2 of a column
  logic [2:0][hbs_pkg::SAMPLE_W+1:0] u;   // rows 0..2 of a column
  logic [2:0][hbs_pkg::SAMPLE_W+1:0] s;   // rows of the upper box

  assign in_take   = in_valid && in_ready;
  assign s2_go     = s2_valid && ((s2_ctl.emit == 4'b0000) || out_ready);
  assign in_ready  = !s2_valid || s2_go;
  assign out_valid = s2_valid && (s2_ctl.emit != 4'b0000);
  assign out_ctl   = s2_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (in_take) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= older;
      win[1][2] <= prev;
      win[2][2] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (in_take) begin
      s2_valid <= 1'b1;
    end else if (s2_go) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s2_ctl <= in_ctl;
    end
  end

  // column sums, then the four boxes
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      t[j] = {1'b0, win[1][j]} + {1'b0, win[2][j]};
      u[j] = {1'b0, t[j]} + {2'b00, win[0][j]};
      s[j] = s2_ctl.rtop ? {1'b0, t[j]} : u[j];
    end
  end

  always_comb begin
    out_sums.sum[hbs_pkg::SLOT_A] = hbs_pkg::SUM_W'(s[1]) + hbs_pkg::SUM_W'(s[2])
                                  + (s2_ctl.cleft ? '0 : hbs_pkg::SUM_W'(s[0]));
    out_sums.sum[hbs_pkg::SLOT_B] = hbs_pkg::SUM_W'(s[1]) + hbs_pkg::SUM_W'(s[2]);
    out_sums.sum[hbs_pkg::SLOT_C] = hbs_pkg::SUM_W'(t[1]) + hbs_pkg::SUM_W'(t[2])
                                  + (s2_ctl.cleft ? '0 : hbs_pkg::SUM_W'(t[0]));
    out_sums.sum[hbs_pkg::SLOT_D] = hbs_pkg::SUM_W'(t[1]) + hbs_pkg::SUM_W'(t[2]);

    if (s2_ctl.rtop && s2_ctl.cleft) begin
      out_sums.div[hbs_pkg::SLOT_A] = hbs_pkg::DIV4;
    end else if (s2_ctl.rtop || s2_ctl.cleft) begin
      out_sums.div[hbs_pkg::SLOT_A] = hbs_pkg::DIV6;
    end else begin
      out_sums.div[hbs_pkg::SLOT_A] = hbs_pkg::DIV9;
    end
    out_sums.div[hbs_pkg::SLOT_B] = s2_ctl.rtop  ? hbs_pkg::DIV4 : hbs_pkg::DIV6;
    out_sums.div[hbs_pkg::SLOT_C] = s2_ctl.cleft ? hbs_pkg::DIV4 : hbs_pkg::DIV6;
    out_sums.div[hbs_pkg::SLOT_D] = hbs_pkg::DIV4;
  end

endmodule

### hw/rtl/hbs_emitter.sv
module hbs_emitter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  hbs_pkg::item_ctl_t         in_ctl,
  input  hbs_pkg::box_sums_t         in_sums,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic [hbs_pkg::ROW_W-1:0]  out_row,
  output logic [hbs_pkg::COL_W-1:0]  out_col,
  output logic [hbs_pkg::MEAN_W-1:0] smoothed,
  output logic                       last_of_run
);

  localparam int OPER_W  = hbs_pkg::SUM_W + 8;
  localparam int RECIP_W = 21;
  localparam int PROD_W  = OPER_W + RECIP_W;
  localparam int DIV6_SHIFT = 20;
  localparam int DIV9_SHIFT = 24;
  // exact reciprocals for the operand range: x/3 and x/9
  localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'((2**DIV6_SHIFT + 2) / 3);
  localparam logic [RECIP_W-1:0] RECIP9 = RECIP_W'((2**DIV9_SHIFT + 8) / 9);

  logic                        s3_valid;
  hbs_pkg::item_ctl_t          s3_ctl;
  hbs_pkg::box_sums_t          s3_sums;
  logic                        s3_take;
  logic                        issue;
  logic [1:0]                  slot;
  logic [3:0]                  remaining;
  logic                        is_last;
  logic [hbs_pkg::SUM_W-1:0]   sum_sel;
  hbs_pkg::div_t               div_sel;
  logic [OPER_W-1:0]           operand;
  logic [RECIP_W-1:0]          recip;
  logic [PROD_W-1:0]           product;
  logic [hbs_pkg::MEAN_W-1:0]  quot;
  logic [hbs_pkg::ROW_W-1:0]   row_sel;
  logic [hbs_pkg::COL_W-1:0]   col_sel;

  assign issue    = s3_valid && (!result_valid || result_ready);
  assign in_ready = !s3_valid || (issue && is_last);
  assign s3_take  = in_valid && in_ready;

  // first pending result in emit order
  always_comb begin
    priority if (s3_ctl.emit[hbs_pkg::SLOT_A]) begin
      slot = hbs_pkg::SLOT_A;
    end else if (s3_ctl.emit[hbs_pkg::SLOT_B]) begin
      slot = hbs_pkg::SLOT_B;
    end else if (s3_ctl.emit[hbs_pkg::SLOT_C]) begin
      slot = hbs_pkg::SLOT_C;
    end else begin
      slot = hbs_pkg::SLOT_D;
    end
  end

  assign remaining = s3_ctl.emit & ~(4'b0001 << slot);
  assign is_last   = (remaining == 4'b0000);
  assign sum_sel   = s3_sums.sum[slot];
  assign div_sel   = s3_sums.div[slot];

  always_comb begin
    unique case (slot)
      hbs_pkg::SLOT_A: begin
        row_sel = s3_ctl.row_up;
        col_sel = s3_ctl.col_left;
      end
      hbs_pkg::SLOT_B: begin
        row_sel = s3_ctl.row_up;
        col_sel = s3_ctl.col_cur;
      end
      hbs_pkg::SLOT_C: begin
        row_sel = s3_ctl.row_cur;
        col_sel = s3_ctl.col_left;
      end
      hbs_pkg::SLOT_D: begin
        row_sel = s3_ctl.row_cur;
        col_sel = s3_ctl.col_cur;
      end
    endcase
  end

  // (512*sum + n) / (2n): n=4 is 64*sum, n=6 is (128*sum+1)/3, n=9 is (256*sum+4)/9
  always_comb begin
    operand = '0;
    recip   = '0;
    unique case (div_sel)
      hbs_pkg::DIV6: begin
        operand = {1'b0, sum_sel, 7'd0} + OPER_W'(1);
        recip   = RECIP3;
      end
      hbs_pkg::DIV9: begin
        operand = {sum_sel, 8'd0} + OPER_W'(4);
        recip   = RECIP9;
      end
      default: begin
      end
    endcase
  end

  assign product = PROD_W'(operand) * PROD_W'(recip);

  always_comb begin
    unique case (div_sel)
      hbs_pkg::DIV4: quot = {sum_sel[9:0], 6'd0};
      hbs_pkg::DIV6: quot = product[DIV6_SHIFT +: hbs_pkg::MEAN_W];
      hbs_pkg::DIV9: quot = product[DIV9_SHIFT +: hbs_pkg::MEAN_W];
      default:       quot = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_take) begin
      s3_valid <= 1'b1;
    end else if (issue && is_last) begin
      s3_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_take) begin
      s3_ctl  <= in_ctl;
      s3_sums <= in_sums;
    end else if (issue) begin
      s3_ctl.emit <= remaining;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (issue) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_row     <= row_sel;
      out_col     <= col_sel;
      smoothed    <= s3_ctl.zero[slot] ? '0 : quot;
      last_of_run <= is_last;
    end
  end

endmodule

### hw/rtl/heightmap_box_smoother_unit.sv
// channel   dir  signals                                            handshake
// ------    ---  -------------------------------------------------  -------------------------
// cfg       in   cfg_index[1:0], cfg_data[12:0]                      cfg_valid / cfg_ready
// sample    in   sample[7:0]                                         sample_valid / sample_ready
// result    out  out_row[12:0], out_col[10:0], smoothed[15:0],       result_valid / result_ready
//                last_of_run
//
// one item per cycle while result_ready is high; an item with k results (k up to 4, at row
// ends and on the bottom row) holds the input back while the single divider
// in the emitter, which issues one result per cycle while result_ready is high, works through them
// an accepted item passes the stage 1, window and emitter registers before its first result
// reaches the output register; reset is synchronous; line stores are not cleared, no warm-up pass
// cfg_ready is always high; stalls on result_ready back up through the stages
module heightmap_box_smoother_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hbs_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  logic [hbs_pkg::SAMPLE_W-1:0]  sample,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [hbs_pkg::ROW_W-1:0]     out_row,
  output logic [hbs_pkg::COL_W-1:0]     out_col,
  output logic [hbs_pkg::MEAN_W-1:0]    smoothed,
  output logic                          last_of_run
);

  // config registers
  logic [hbs_pkg::COL_W-1:0] frame_width;
  logic [hbs_pkg::ROW_W-1:0] frame_height;
  logic                      zero_edges;

  // raster position of the next item
  logic [hbs_pkg::ROW_W-1:0] in_row_count;
  logic [hbs_pkg::COL_W-1:0] in_col_count;

  // effective sizes and the position of this item
  logic [hbs_pkg::COL_W-1:0] w_eff;
  logic [hbs_pkg::ROW_W-1:0] h_eff;
  logic [hbs_pkg::COL_W-1:0] col;
  logic [hbs_pkg::ROW_W-1:0] row;
  logic                      col_last;
  logic                      row_last;
  logic                      col_nz;
  logic                      row_nz;
  hbs_pkg::item_ctl_t        ctl;

  // stage 1: accepted sample waiting for the line store read
  logic                        s1_valid;
  logic [hbs_pkg::SAMPLE_W-1:0] s1_sample;
  hbs_pkg::item_ctl_t          s1_ctl;
  logic [hbs_pkg::ADDR_W-1:0]  s1_addr;
  logic                        s1_adv;
  logic                        sample_take;

  hbs_pkg::line_pair_t rd_pair;
  hbs_pkg::line_pair_t wr_pair;

  logic               win_ready;
  logic               s2_valid;
  logic               s3_ready;
  hbs_pkg::item_ctl_t s2_ctl;
  hbs_pkg::box_sums_t s2_sums;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= hbs_pkg::FRAME_WIDTH_RST;
      frame_height <= hbs_pkg::FRAME_HEIGHT_RST;
      zero_edges   <= hbs_pkg::ZERO_EDGES_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hbs_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data[hbs_pkg::COL_W-1:0];
        hbs_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data[hbs_pkg::ROW_W-1:0];
        hbs_pkg::CFG_ZERO_EDGES:   zero_edges   <= cfg_data[0];
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  // clamp the sizes: width to 3..line store depth, height to at least 3
  always_comb begin
    priority if (frame_width < hbs_pkg::COL_W'(hbs_pkg::MIN_SIZE)) begin
      w_eff = hbs_pkg::COL_W'(hbs_pkg::MIN_SIZE);
    end else if (frame_width > hbs_pkg::COL_W'(hbs_pkg::MAX_WIDTH)) begin
      w_eff = hbs_pkg::COL_W'(hbs_pkg::MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    h_eff = (frame_height < hbs_pkg::ROW_W'(hbs_pkg::MIN_SIZE)) ?
            hbs_pkg::ROW_W'(hbs_pkg::MIN_SIZE) : frame_height;
  end

  // a count left past a shrunken size restarts at zero
  assign col      = (in_col_count >= w_eff) ? '0 : in_col_count;
  assign row      = (in_row_count >= h_eff) ? '0 : in_row_count;
  assign col_last = (col == w_eff - hbs_pkg::COL_W'(1));
  assign row_last = (row == h_eff - hbs_pkg::ROW_W'(1));
  assign col_nz   = (col != '0);
  assign row_nz   = (row != '0);

  // which results this item releases, and where they sit
  always_comb begin
    ctl.emit[hbs_pkg::SLOT_A] = row_nz && col_nz;
    ctl.emit[hbs_pkg::SLOT_B] = row_nz && col_last;
    ctl.emit[hbs_pkg::SLOT_C] = row_last && col_nz;
    ctl.emit[hbs_pkg::SLOT_D] = row_last && col_last;
    // only the trailing position can be interior; the others lie on the border
    ctl.zero[hbs_pkg::SLOT_A] = zero_edges &&
                                ((row == hbs_pkg::ROW_W'(1)) || (col == hbs_pkg::COL_W'(1)));
    ctl.zero[hbs_pkg::SLOT_B] = zero_edges;
    ctl.zero[hbs_pkg::SLOT_C] = zero_edges;
    ctl.zero[hbs_pkg::SLOT_D] = zero_edges;
    // top window row is outside the frame while centered on row 0
    ctl.rtop     = (row < hbs_pkg::ROW_W'(2));
    // left window column is outside the frame while centered on col 0
    ctl.cleft    = (col < hbs_pkg::COL_W'(2));
    ctl.row_up   = row - hbs_pkg::ROW_W'(1);
    ctl.row_cur  = row;
    ctl.col_left = col - hbs_pkg::COL_W'(1);
    ctl.col_cur  = col;
  end

  assign sample_take  = sample_valid && sample_ready;
  assign s1_adv       = s1_valid && win_ready;
  assign sample_ready = !s1_valid || win_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row_count <= '0;
      in_col_count <= '0;
    end else if (sample_take) begin
      if (col_last) begin
        in_col_count <= '0;
        in_row_count <= row_last ? '0 : row + hbs_pkg::ROW_W'(1);
      end else begin
        in_col_count <= col + hbs_pkg::COL_W'(1);
        in_row_count <= row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_take) begin
      s1_sample <= sample;
      s1_ctl    <= ctl;
      s1_addr   <= hbs_pkg::ADDR_W'(col);
    end
  end

  // the previous row moves to the older slot, the new sample becomes the previous row
  assign wr_pair.older = rd_pair.prev;
  assign wr_pair.prev  = s1_sample;

  hbs_line_store u_line_store (
    .clk     (clk),
    .rd_en   (sample_take),
    .rd_addr (hbs_pkg::ADDR_W'(col)),
    .rd_data (rd_pair),
    .wr_en   (s1_adv),
    .wr_addr (s1_addr),
    .wr_data (wr_pair)
  );

  // 3x3 window and the box sums
  hbs_window u_window (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (win_ready),
    .older     (rd_pair.older),
    .prev      (rd_pair.prev),
    .sample    (s1_sample),
    .in_ctl    (s1_ctl),
    .out_valid (s2_valid),
    .out_ready (s3_ready),
    .out_ctl   (s2_ctl),
    .out_sums  (s2_sums)
  );

  // one result per cycle while result_ready allows: mean, border forcing, output register
  hbs_emitter u_emitter (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s2_valid),
    .in_ready     (s3_ready),
    .in_ctl       (s2_ctl),
    .in_sums      (s2_sums),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_row      (out_row),
    .out_col      (out_col),
    .smoothed     (smoothed),
    .last_of_run  (last_of_run)
  );

endmodule

### hw/rtl/hbs_checker.sv
module hbs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          result_valid,
  input logic                          result_ready,
  input logic [hbs_pkg::ROW_W-1:0]     out_row,
  input logic [hbs_pkg::COL_W-1:0]     out_col,
  input logic [hbs_pkg::MEAN_W-1:0]    smoothed,
  input logic                          last_of_run
);

  // a stalled result holds its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(out_row) && $stable(out_col) &&
      $stable(smoothed) && $stable(last_of_run))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // the rest of a run follows without a gap
  a_run_gapless: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !last_of_run |=> result_valid)
    else $error("gap inside a run of results");

  // results of one run stay on one row or step down one row
  a_run_rows: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !last_of_run |=>
      (out_row == $past(out_row)) || (out_row == $past(out_row) + 13'd1))
    else $error("row jump inside a run of results");

endmodule

bind heightmap_box_smoother_unit hbs_checker u_hbs_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .out_row      (out_row),
  .out_col      (out_col),
  .smoothed     (smoothed),
  .last_of_run  (last_of_run)
);
